// File: design/paid_pkg.sv
// shared types, codes and defaults for the positional array insert/delete block
package paid_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned WORD_BITS_DEF = 32;

  // fixed field widths
  localparam int unsigned POS_BITS      = 8;
  localparam int unsigned VALUE_BITS    = 32;
  localparam int unsigned CAP_BITS      = 5;
  localparam int unsigned CNT_OUT_BITS  = 5;
  localparam int unsigned STATUS_BITS   = 2;
  localparam int unsigned MODE_BITS     = 2;
  localparam int unsigned IN_DATA_BITS  = 40;
  localparam int unsigned OUT_DATA_BITS = 40;

  // capacity after reset
  localparam int unsigned CAP_RESET     = 16;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_APPEND = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // ram read address select
  typedef enum logic [1:0] {
    RD_PREV = 2'd0,
    RD_NEXT = 2'd1,
    RD_POS  = 2'd2
  } rd_sel_e;

  // ram write address and data select
  typedef enum logic [1:0] {
    WR_APPEND = 2'd0,
    WR_SHIFT  = 2'd1,
    WR_INSERT = 2'd2
  } wr_sel_e;

  // commands from controller to datapath
  typedef struct packed {
    logic    latch_in;
    logic    ld_ptr_cnt;
    logic    ld_ptr_pos;
    logic    ptr_dec;
    logic    ptr_inc;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_status;
    status_e status;
    logic    cap_word;
    logic    load_out;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  pos_gt_cnt;
    logic  pos_ge_cnt;
    logic  pos_is_cnt;
    logic  pos_next_last;
    logic  full;
    logic  ptr_prev_is_pos;
    logic  ptr_next_last;
  } dp_status_t;

endpackage

// File: design/paid_ram.sv
// generic single write port ram with registered read
module paid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/paid_ctrl.sv
// controller state machine for the positional array
module paid_ctrl
  import paid_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t st_i,
  output cmd_t       cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_EVAL    = 9'b000000010,
    S_RD_WAIT = 9'b000000100,
    S_UP_RD   = 9'b000001000,
    S_UP_WR   = 9'b000010000,
    S_INS_WR  = 9'b000100000,
    S_DN_RD   = 9'b001000000,
    S_DN_WR   = 9'b010000000,
    S_FIN     = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    cmd.rd_sel = RD_POS;
    cmd.wr_sel = WR_APPEND;
    cmd.status = ST_DONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.latch_in = 1'b1;
          state_d      = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.set_status = 1'b1;
        state_d        = S_FIN;
        unique case (st_i.mode)
          MODE_APPEND: begin
            if (st_i.full) begin
              cmd.status = ST_FULL;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_sel  = WR_APPEND;
              cmd.cnt_inc = 1'b1;
            end
          end
          MODE_INSERT: begin
            if (st_i.pos_gt_cnt) begin
              cmd.status = ST_INVALID;
            end else if (st_i.full) begin
              cmd.status = ST_FULL;
            end else if (st_i.pos_is_cnt) begin
              cmd.wr_en   = 1'b1;
              cmd.wr_sel  = WR_INSERT;
              cmd.cnt_inc = 1'b1;
            end else begin
              cmd.ld_ptr_cnt = 1'b1;
              state_d        = S_UP_RD;
            end
          end
          MODE_DELETE: begin
            if (st_i.pos_ge_cnt) begin
              cmd.status = ST_INVALID;
            end else if (st_i.pos_next_last) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              cmd.ld_ptr_pos = 1'b1;
              state_d        = S_DN_RD;
            end
          end
          MODE_READ: begin
            if (st_i.pos_ge_cnt) begin
              cmd.status = ST_INVALID;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_POS;
              state_d    = S_RD_WAIT;
            end
          end
          default: begin
            cmd.status = ST_INVALID;
          end
        endcase
      end
      S_RD_WAIT: begin
        cmd.cap_word = 1'b1;
        state_d      = S_FIN;
      end
      // shift up: read entry below the pointer, then write it at the pointer
      S_UP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PREV;
        state_d    = S_UP_WR;
      end
      S_UP_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.ptr_dec = 1'b1;
        state_d     = st_i.ptr_prev_is_pos ? S_INS_WR : S_UP_RD;
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_INSERT;
        cmd.cnt_inc = 1'b1;
        state_d     = S_FIN;
      end
      // shift down: read entry above the pointer, then write it at the pointer
      S_DN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_NEXT;
        state_d    = S_DN_WR;
      end
      S_DN_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.ptr_inc = 1'b1;
        if (st_i.ptr_next_last) begin
          cmd.cnt_dec = 1'b1;
          state_d     = S_FIN;
        end else begin
          state_d = S_DN_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o = cmd;

  // the count only grows while the array has room
  a_inc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_inc |-> !st_i.full)
    else $error("count increment while array full");

endmodule

// File: design/paid_dp.sv
// datapath: item registers, entry ram, count, shift pointer and result registers
module paid_dp
  import paid_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CAP_BITS-1:0]         cfg_data_i,
  input  mode_e                       in_mode_i,
  input  logic [POS_BITS-1:0]         in_pos_i,
  input  logic signed [VALUE_BITS-1:0] in_value_i,
  input  cmd_t                        cmd_i,
  output dp_status_t                  st_o,
  output status_e                     out_status_o,
  output logic [CNT_OUT_BITS-1:0]     out_count_o,
  output logic signed [VALUE_BITS-1:0] out_word_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = ((CW > POS_BITS) ? CW : POS_BITS) + 2;

  // item registers
  mode_e                 mode_q;
  logic [POS_BITS-1:0]   pos_q;
  logic [WORD_BITS-1:0]  value_q;

  // control registers
  logic [CW-1:0]         count_q, count_d;
  logic [CAP_BITS-1:0]   cap_q;
  logic [AW-1:0]         ptr_q, ptr_d;

  // result registers
  status_e               res_status_q;
  logic [VALUE_BITS-1:0] res_word_q;
  status_e               out_status_q;
  logic [CNT_OUT_BITS-1:0] out_count_q;
  logic [VALUE_BITS-1:0] out_word_q;

  // ram ports
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [WORD_BITS-1:0]  ram_rdata;

  // wide copies for compares
  logic [CMPW-1:0]       pos_w, cnt_w, ptr_w, lim_w, cap_w, dep_w;

  assign pos_w = CMPW'(pos_q);
  assign cnt_w = CMPW'(count_q);
  assign ptr_w = CMPW'(ptr_q);
  assign cap_w = CMPW'(cap_q);
  assign dep_w = CMPW'(DEPTH);
  assign lim_w = (cap_w > dep_w) ? dep_w : cap_w;

  // status toward the controller
  assign st_o.mode            = mode_q;
  assign st_o.pos_gt_cnt      = pos_w > cnt_w;
  assign st_o.pos_ge_cnt      = pos_w >= cnt_w;
  assign st_o.pos_is_cnt      = pos_w == cnt_w;
  assign st_o.pos_next_last   = (pos_w + CMPW'(1)) >= cnt_w;
  assign st_o.full            = cnt_w >= lim_w;
  assign st_o.ptr_prev_is_pos = ptr_w == (pos_w + CMPW'(1));
  assign st_o.ptr_next_last   = (ptr_w + CMPW'(2)) >= cnt_w;

  // ram read address
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_PREV: ram_raddr = ptr_q - AW'(1);
      RD_NEXT: ram_raddr = ptr_q + AW'(1);
      RD_POS:  ram_raddr = AW'(pos_q);
      default: ram_raddr = AW'(pos_q);
    endcase
  end

  // ram write address and data
  always_comb begin
    ram_we = cmd_i.wr_en;
    unique case (cmd_i.wr_sel)
      WR_APPEND: begin
        ram_waddr = AW'(count_q);
        ram_wdata = value_q;
      end
      WR_SHIFT: begin
        ram_waddr = ptr_q;
        ram_wdata = ram_rdata;
      end
      WR_INSERT: begin
        ram_waddr = AW'(pos_q);
        ram_wdata = value_q;
      end
      default: begin
        ram_waddr = ptr_q;
        ram_wdata = value_q;
      end
    endcase
  end

  paid_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // count and pointer next values
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    priority if (cmd_i.ld_ptr_cnt) begin
      ptr_d = AW'(count_q);
    end else if (cmd_i.ld_ptr_pos) begin
      ptr_d = AW'(pos_q);
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_q - AW'(1);
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + AW'(1);
    end else begin
      ptr_d = ptr_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CAP_BITS'(CAP_RESET);
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.latch_in) begin
      mode_q  <= in_mode_i;
      pos_q   <= in_pos_i;
      value_q <= WORD_BITS'(in_value_i);
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status;
      res_word_q   <= '0;
    end
    if (cmd_i.cap_word) begin
      res_word_q <= VALUE_BITS'($signed(ram_rdata));
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_count_q  <= CNT_OUT_BITS'(count_q);
      out_word_q   <= res_word_q;
    end
  end

  assign out_status_o = out_status_q;
  assign out_count_o  = out_count_q;
  assign out_word_o   = $signed(out_word_q);

  // count never passes the depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_w <= dep_w)
    else $error("element count above depth");

  // writes stay inside the ram
  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CMPW'(ram_waddr) < dep_w))
    else $error("ram write address out of range");

endmodule

// File: design/positional_array_insert_delete_core.sv
// top level of the positional array with insert, delete, append and read
// A packed list of signed words with a live count, backed by a single ram that
// has one write port and one registered read port. An append, a failed operation,
// an insert at the end and a delete of the last entry go from evaluation straight
// to the finish state, which loads the output register; a read first waits for the
// registered ram read. Insert and delete elsewhere move the later entries one at a
// time through the ram, a ram read and a ram write per moved entry, where moved is
// count minus position for insert and count minus position minus one for delete.
// The block is idle again in the cycle after its result is loaded.
// A new item is taken once the previous one has its result in the output
// register, even while that result still waits on m_axis_tready. The capacity
// register is written over the cfg channel, always ready; the user must write it
// only while idle, since the block itself does not enforce this.
module positional_array_insert_delete_core
  import paid_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write channel: capacity
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CAP_BITS-1:0]      cfg_data_i,
  // input items
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,  // [7:0] position, [39:8] value
  input  logic [MODE_BITS-1:0]     s_axis_tuser,  // [1:0] mode
  // result items
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,  // [4:0] count_after, [36:5] read_word
  output logic [STATUS_BITS-1:0]   m_axis_tuser   // [1:0] status
);

  cmd_t                          cmd;
  dp_status_t                    dp_st;
  status_e                       out_status;
  logic [CNT_OUT_BITS-1:0]       out_count;
  logic signed [VALUE_BITS-1:0]  out_word;
  mode_e                         in_mode;
  logic [POS_BITS-1:0]           in_pos;
  logic signed [VALUE_BITS-1:0]  in_value;

  // unpack input item
  assign in_mode  = mode_e'(s_axis_tuser);
  assign in_pos   = s_axis_tdata[POS_BITS-1:0];
  assign in_value = $signed(s_axis_tdata[POS_BITS+VALUE_BITS-1:POS_BITS]);

  assign cfg_ready_o = 1'b1;

  paid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .st_i        (dp_st),
    .cmd_o       (cmd)
  );

  paid_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_mode_i    (in_mode),
    .in_pos_i     (in_pos),
    .in_value_i   (in_value),
    .cmd_i        (cmd),
    .st_o         (dp_st),
    .out_status_o (out_status),
    .out_count_o  (out_count),
    .out_word_o   (out_word)
  );

  // pack result item
  assign m_axis_tdata = {
    (OUT_DATA_BITS - CNT_OUT_BITS - VALUE_BITS)'(0),
    out_word,
    out_count
  };
  assign m_axis_tuser = out_status;

  // only a successful read carries a nonzero word
  a_word_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_status != ST_DONE)) |-> (out_word == '0))
    else $error("nonzero read word on failed operation");

endmodule

// File: tb/positional_array_insert_delete_core_test.sv
// self-checking testbench for the positional array insert/delete core
module positional_array_insert_delete_core_test;
  import paid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_DEPTH = DEPTH_DEF;
  localparam int unsigned LIST_AW    = $clog2(LIST_DEPTH);

  // one requested list operation
  typedef struct {
    mode_e             mode;
    logic [7:0]        pos;
    logic [31:0]       value;
  } list_op_t;

  // one result of a list operation
  typedef struct {
    status_e           status;
    logic [4:0]        count;
    logic [31:0]       word;
  } list_result_t;

  // phase flavors for random operations
  localparam int FLAVOR_FILL  = 0;
  localparam int FLAVOR_DRAIN = 1;
  localparam int FLAVOR_MIXED = 2;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CAP_BITS-1:0]      cfg_data_i = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;  // [7:0] position, [39:8] value
  logic [MODE_BITS-1:0]     s_axis_tuser = '0;  // [1:0] mode
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;       // [4:0] count_after, [36:5] read_word
  logic [STATUS_BITS-1:0]   m_axis_tuser;       // [1:0] status

  // shadow copy of the list and the capacity register
  logic [31:0]  list_words [LIST_DEPTH];
  int           live_count = 0;
  int           cap_q = CAP_RESET;

  list_op_t     pending_ops[$];
  list_result_t expected_results[$];
  int           ops_open = 0;

  // flow control knobs
  int           idle_pct = 0;
  bit           quiet = 1'b0;
  int           send_gap = 0;
  int           stall_left = 0;
  int           hold_cycles = 0;
  bit           op_taken = 1'b0;

  // bookkeeping
  int           errors = 0;
  int           ops_accepted = 0;
  int           cap_writes = 0;
  int           status_seen [3] = '{0, 0, 0};
  int           mode_seen [4] = '{0, 0, 0, 0};
  int           peak_count = 0;

  positional_array_insert_delete_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // apply one operation to the shadow list and return its result
  function automatic list_result_t apply_list_op(input list_op_t op);
    list_result_t r;
    int           lim;
    r.status = ST_DONE;
    r.word   = '0;
    lim = (cap_q > LIST_DEPTH) ? LIST_DEPTH : cap_q;
    case (op.mode)
      MODE_APPEND: begin
        if (live_count >= lim) begin
          r.status = ST_FULL;
        end else begin
          list_words[LIST_AW'(live_count)] = op.value;
          live_count++;
        end
      end
      MODE_INSERT: begin
        // position is checked before fullness
        if (int'(op.pos) > live_count) begin
          r.status = ST_INVALID;
        end else if (live_count >= lim) begin
          r.status = ST_FULL;
        end else begin
          for (int i = live_count; i > int'(op.pos); i--) begin
            list_words[LIST_AW'(i)] = list_words[LIST_AW'(i-1)];
          end
          list_words[LIST_AW'(op.pos)] = op.value;
          live_count++;
        end
      end
      MODE_DELETE: begin
        if (int'(op.pos) >= live_count) begin
          r.status = ST_INVALID;
        end else begin
          for (int i = int'(op.pos); i + 1 < live_count; i++) begin
            list_words[LIST_AW'(i)] = list_words[LIST_AW'(i+1)];
          end
          live_count--;
        end
      end
      default: begin
        if (int'(op.pos) >= live_count) r.status = ST_INVALID;
        else r.word = list_words[LIST_AW'(op.pos)];
      end
    endcase
    r.count = live_count[4:0];
    return r;
  endfunction

  // sender: one item per handshake, random gaps between items
  always @(negedge clk_i) begin
    list_op_t nx;
    logic     v;
    if (rst_ni && (!s_axis_tvalid || op_taken)) begin
      v = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_ops.size() > 0) begin
        nx = pending_ops.pop_front();
        v = 1'b1;
        s_axis_tdata <= {nx.value, nx.pos};
        s_axis_tuser <= nx.mode;
        if (!quiet && $urandom_range(0, 99) < idle_pct) send_gap = $urandom_range(1, 5);
      end
      s_axis_tvalid <= v;
    end
    op_taken = 1'b0;
  end

  // receiver: random stall bursts plus the long hold-off when asked
  always @(negedge clk_i) begin
    logic r;
    r = 1'b1;
    if (hold_cycles > 0) begin
      hold_cycles--;
      r = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      r = 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 4);
      r = 1'b0;
    end
    m_axis_tready <= r;
  end

  // monitor: check results, then predict for newly accepted items
  always @(posedge clk_i) begin
    list_op_t     op;
    list_result_t want;
    logic [4:0]   got_count;
    logic [31:0]  got_word;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_count = m_axis_tdata[4:0];
        got_word  = m_axis_tdata[36:5];
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: status %0d count %0d word %h",
                   $realtime, m_axis_tuser, got_count, got_word);
        end else begin
          want = expected_results.pop_front();
          ops_open--;
          if (m_axis_tuser < 3) status_seen[m_axis_tuser]++;
          if (m_axis_tuser !== want.status || got_count !== want.count ||
              got_word !== want.word) begin
            errors++;
            $display("%0t: mismatch: expected status %0d count %0d word %h,",
                     $realtime, want.status, want.count, want.word,
                     " got status %0d count %0d word %h",
                     m_axis_tuser, got_count, got_word);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        op.mode  = mode_e'(s_axis_tuser);
        op.pos   = s_axis_tdata[7:0];
        op.value = s_axis_tdata[39:8];
        expected_results.push_back(apply_list_op(op));
        mode_seen[op.mode]++;
        if (live_count > peak_count) peak_count = live_count;
        ops_accepted++;
        op_taken = 1'b1;
      end
    end
  end

  task automatic push_op(input mode_e mode, input logic [7:0] pos, input logic [31:0] value);
    list_op_t op;
    op.mode  = mode;
    op.pos   = pos;
    op.value = value;
    pending_ops.push_back(op);
    ops_open++;
  endtask

  // write the capacity register over the config channel
  task automatic write_capacity(input logic [4:0] cap);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cap_q = int'(cap);
    cap_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // hold until every queued item has produced its result
  task automatic wait_drained();
    while (ops_open > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // random operation shaped by the phase flavor
  task automatic push_random_op(input int flavor);
    int          r;
    mode_e       mode;
    logic [7:0]  pos;
    logic [31:0] value;
    r = $urandom_range(0, 99);
    case (flavor)
      FLAVOR_FILL:  mode = (r < 40) ? MODE_APPEND : (r < 75) ? MODE_INSERT :
                           (r < 88) ? MODE_DELETE : MODE_READ;
      FLAVOR_DRAIN: mode = (r < 10) ? MODE_APPEND : (r < 25) ? MODE_INSERT :
                           (r < 70) ? MODE_DELETE : MODE_READ;
      default:      mode = mode_e'(r % 4);
    endcase
    // mostly positions around the live range, sometimes anywhere
    if ($urandom_range(0, 9) == 0) pos = 8'($urandom_range(0, 255));
    else pos = 8'($urandom_range(0, 17));
    case ($urandom_range(0, 19))
      0:       value = 32'h8000_0000;
      1:       value = 32'h7fff_ffff;
      2:       value = 32'h0000_0000;
      3:       value = 32'hffff_ffff;
      default: value = $urandom;
    endcase
    push_op(mode, pos, value);
  endtask

  // timeout
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // stimulus sequence
  initial begin
    logic [4:0] cap_plan [14] = '{5'd31, 5'd16, 5'd16, 5'd1, 5'd2, 5'd0, 5'd17,
                                   5'd8, 5'd16, 5'd5, 5'd31, 5'd3, 5'd16, 5'd16};
    int         flavor_plan [14] = '{FLAVOR_FILL, FLAVOR_MIXED, FLAVOR_FILL, FLAVOR_MIXED,
                                     FLAVOR_FILL, FLAVOR_DRAIN, FLAVOR_FILL, FLAVOR_MIXED,
                                     FLAVOR_DRAIN, FLAVOR_MIXED, FLAVOR_FILL, FLAVOR_MIXED,
                                     FLAVOR_FILL, FLAVOR_DRAIN};
    int         pct_plan [3] = '{0, 10, 30};
    logic [4:0] cap;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty list, word extremes, edge positions, default capacity
    idle_pct = 20;
    push_op(MODE_READ,   8'd0,   32'h0);
    push_op(MODE_DELETE, 8'd0,   32'h0);
    push_op(MODE_INSERT, 8'd1,   32'h1234_5678);
    push_op(MODE_INSERT, 8'd0,   32'h8000_0000);
    push_op(MODE_APPEND, 8'd0,   32'h7fff_ffff);
    push_op(MODE_APPEND, 8'd0,   32'hffff_ffff);
    push_op(MODE_INSERT, 8'd3,   32'h0000_0000);
    push_op(MODE_INSERT, 8'd1,   32'h5555_5555);
    push_op(MODE_READ,   8'd0,   32'h0);
    push_op(MODE_READ,   8'd4,   32'h0);
    push_op(MODE_READ,   8'd5,   32'h0);
    push_op(MODE_READ,   8'd255, 32'h0);
    push_op(MODE_DELETE, 8'd255, 32'h0);
    push_op(MODE_INSERT, 8'd255, 32'h0);
    push_op(MODE_DELETE, 8'd0,   32'h0);
    push_op(MODE_DELETE, 8'd3,   32'h0);
    push_op(MODE_APPEND, 8'd255, 32'haaaa_aaaa);
    wait_drained();

    // capacity below count: grow ops report full, bad insert position still invalid
    write_capacity(5'd0);
    push_op(MODE_APPEND, 8'd0,   32'h0bad_cafe);
    push_op(MODE_INSERT, 8'd0,   32'h0bad_cafe);
    push_op(MODE_INSERT, 8'd200, 32'h0bad_cafe);
    push_op(MODE_READ,   8'd1,   32'h0);
    push_op(MODE_DELETE, 8'd1,   32'h0);
    wait_drained();

    // random phases over a spread of capacities
    for (int p = 0; p < 14; p++) begin
      cap = (p == 9) ? 5'($urandom_range(0, 31)) : cap_plan[p];
      write_capacity(cap);
      quiet    = (p >= 12);
      idle_pct = pct_plan[$urandom_range(0, 2)];
      if (p == 2) idle_pct = 10;
      // long receiver hold-off so the block backs up into its input
      if (p == 2) hold_cycles = 150;
      for (int k = 0; k < 102; k++) push_random_op(flavor_plan[p]);
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    $display("covered %0d items (append %0d, insert %0d, delete %0d, read %0d),",
             ops_accepted, mode_seen[MODE_APPEND], mode_seen[MODE_INSERT],
             mode_seen[MODE_DELETE], mode_seen[MODE_READ],
             " %0d capacity writes", cap_writes);
    $display("results: done %0d, invalid %0d, full %0d; peak list length %0d; %0d errors",
             status_seen[ST_DONE], status_seen[ST_INVALID], status_seen[ST_FULL],
             peak_count, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: positional_array_insert_delete_core.f
design/paid_pkg.sv
design/paid_ram.sv
design/paid_ctrl.sv
design/paid_dp.sv
design/positional_array_insert_delete_core.sv
tb/positional_array_insert_delete_core_test.sv
